// ----- rtl/ebw_pkg.sv -----
// Shared constants, kind codes and channel payload types for the Exp-Golomb bit writer.
package ebw_pkg;

   // Stream capacity in bytes; bits past this point are dropped.
   localparam int CAPACITY = 1024;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int LEFT_W   = (CNT_W > 4) ? CNT_W : 4;

   // Most bytes one element can complete (7 pending bits plus a 65-bit ue code).
   localparam int MAX_RES  = 9;
   localparam int WIN_W    = 72;

   typedef enum logic [2:0] {
      KIND_FIXED   = 3'd0,
      KIND_UE      = 3'd1,
      KIND_SE      = 3'd2,
      KIND_TRAIL   = 3'd3,
      KIND_FLUSH   = 3'd4,
      KIND_RESTART = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [5:0]  bit_width;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        is_last;
      logic        overflowed;
      logic [13:0] bit_total;
   } rsp_type;

endpackage

// ----- rtl/exp_golomb_bit_writer.sv -----
// Exp-Golomb / fixed-width bit packer producing a byte stream, one byte per transaction.
//
// Each req transaction carries one syntax element (u(n), ue(v), se(v), RBSP trailing bits,
// flush or restart). Bits are packed MSB first; every byte completed by an element is sent
// as its own rsp transaction, the last one flagged with is_last, and an element that
// completes no byte gives a single status transaction (byte_valid low, out_byte zero).
// Flush returns the pending partial byte zero-padded, byte_valid set only if it holds bits,
// and leaves the packer state alone. Restart clears everything. Once CAPACITY bytes are
// done, further bits are dropped and overflowed stays set until restart. Every rsp carries
// the overflow flag and the bit count (bytes*8 + bit position, low 14 bits) as they stand
// after the element. Timing: an element goes through four pipeline registers (input, code
// build, leading-one search, left alignment) and is then packed into the result buffer,
// which presents its first rsp. The result buffer drains one transaction per cycle while
// rsp_stall is low, and an element producing n results holds the rsp side until all n are
// taken. The block sustains one element per cycle while each gives a single result and the
// rsp side does not stall; a long ue code that spills bytes gives up to 9 results.
// No clearing pass after reset; the block takes elements in the cycle after reset drops.
module exp_golomb_bit_writer
   import ebw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,

   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,

   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // code built from the element: ue/se code word v+1, or the raw u(n) operand
   typedef struct packed {
      logic [2:0]  kind;
      logic [32:0] code;
      logic [5:0]  bit_width;
   } code_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [32:0] code;
      logic [5:0]  bit_width;
      logic [5:0]  msb;
   } lead_type;

   // bit string left aligned in the 72-bit window, with its length
   typedef struct packed {
      logic [2:0]       kind;
      logic [WIN_W-1:0] bits;
      logic [6:0]       len;
   } align_type;

   // index of the leading one of a ue code word
   function automatic logic [5:0] msb_index(input logic [32:0] v);
      logic [5:0] idx;
      idx = 6'd0;
      for (int i = 0; i < 33; i++) begin
         if (v[i]) idx = 6'(i);
      end
      return idx;
   endfunction

   // ---------------- pipeline control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;
   logic free2, free3, free4;
   logic buf_free, buf_done, rsp_take;

   // ---------------- stage registers ----------------
   req_type   p1_ff, p1_in;
   code_type  p2_ff, p2_in;
   lead_type  p3_ff, p3_in;
   align_type p4_ff, p4_in;

   logic [31:0] neg_value;
   logic [71:0] fixed_aligned;

   // ---------------- packer state ----------------
   logic [7:0]        partial_ff, partial_in;
   logic [2:0]        bp_ff, bp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic              ovf_ff, ovf_in;

   // ---------------- result buffer ----------------
   logic             buf_valid_ff, buf_valid_in;
   logic [3:0]       buf_idx_ff, buf_idx_in;
   logic [3:0]       buf_n_ff, buf_n_in;
   logic             buf_bv_ff, buf_bv_in;
   logic             buf_ovf_ff, buf_ovf_in;
   logic [13:0]      buf_total_ff, buf_total_in;
   logic [7:0]       buf_bytes_ff [MAX_RES];
   logic [7:0]       buf_bytes_in [MAX_RES];

   // ---------------- packing datapath ----------------
   logic [3:0]       room;
   logic [6:0]       avail, item_len, put_len, fill;
   logic             dropped;
   logic [WIN_W-1:0] shifted, keep_mask, window;
   logic [9:0][7:0]  win_bytes;
   logic [3:0]       nbytes;
   logic [CNT_W+2:0] total_full;

   // ---------------- handshake ----------------
   assign rsp_take = buf_valid_ff && !rsp_stall;
   assign buf_done = rsp_take && (buf_idx_ff == buf_n_ff - 4'd1);
   assign buf_free = !buf_valid_ff || buf_done;

   assign adv4  = v4_ff && buf_free;
   assign free4 = !v4_ff || adv4;
   assign adv3  = v3_ff && free4;
   assign free3 = !v3_ff || adv3;
   assign adv2  = v2_ff && free3;
   assign free2 = !v2_ff || adv2;
   assign adv1  = v1_ff && free2;

   assign req_stall = v1_ff && !free2;

   assign v1_in = (req_valid && !req_stall) || (v1_ff && !adv1);
   assign v2_in = adv1 || (v2_ff && !adv2);
   assign v3_in = adv2 || (v3_ff && !adv3);
   assign v4_in = adv3 || (v4_ff && !adv4);

   assign p1_in = req_data;

   // ---------------- stage 2: code word ----------------
   assign neg_value = 32'd0 - p1_ff.value;

   always_comb begin
      p2_in.kind      = p1_ff.kind;
      p2_in.bit_width = p1_ff.bit_width;
      case (p1_ff.kind)
         KIND_UE: begin
            p2_in.code = {1'b0, p1_ff.value} + 33'd1;
         end
         KIND_SE: begin
            // zig-zag then +1: v <= 0 gives (-2v mod 2^32) + 1, v > 0 gives 2v
            if (p1_ff.value[31] || (p1_ff.value == 32'd0)) begin
               p2_in.code = {1'b0, neg_value[30:0], 1'b1};
            end else begin
               p2_in.code = {p1_ff.value, 1'b0};
            end
         end
         default: begin
            p2_in.code = {1'b0, p1_ff.value};
         end
      endcase
   end

   // ---------------- stage 3: leading one ----------------
   always_comb begin
      p3_in.kind      = p2_ff.kind;
      p3_in.code      = p2_ff.code;
      p3_in.bit_width = p2_ff.bit_width;
      p3_in.msb       = msb_index(p2_ff.code);
   end

   // ---------------- stage 4: left alignment ----------------
   assign fixed_aligned = {p3_ff.code[31:0], 40'd0};

   always_comb begin
      p4_in.kind = p3_ff.kind;
      case (p3_ff.kind)
         KIND_FIXED: begin
            // widths above 32 shift in leading zeros
            p4_in.len = {1'b0, p3_ff.bit_width};
            if (p3_ff.bit_width <= 6'd32) begin
               p4_in.bits = fixed_aligned << (6'd32 - p3_ff.bit_width);
            end else begin
               p4_in.bits = fixed_aligned >> (p3_ff.bit_width - 6'd32);
            end
         end
         KIND_UE, KIND_SE: begin
            // msb zeros then the code word: 2*msb+1 bits
            p4_in.len  = {p3_ff.msb, 1'b1};
            p4_in.bits = {39'd0, p3_ff.code} << (7'd71 - {p3_ff.msb, 1'b0});
         end
         KIND_TRAIL: begin
            // stop bit; its length depends on the live bit position
            p4_in.len  = 7'd0;
            p4_in.bits = {1'b1, 71'd0};
         end
         default: begin
            p4_in.len  = 7'd0;
            p4_in.bits = '0;
         end
      endcase
   end

   // ---------------- stage 5: pack into the byte window ----------------
   always_comb begin
      room = (left_ff >= LEFT_W'(MAX_RES)) ? 4'(MAX_RES) : left_ff[3:0];
      // bits that still fit before capacity; at least 65 when far from it
      avail = (room == 4'd0) ? 7'd0 : ({room, 3'b000} - {4'd0, bp_ff});
      if (p4_ff.kind == KIND_TRAIL) begin
         item_len = 7'd8 - {4'd0, bp_ff};
      end else begin
         item_len = p4_ff.len;
      end
      dropped   = item_len > avail;
      put_len   = dropped ? avail : item_len;
      fill      = {4'd0, bp_ff} + put_len;
      shifted   = p4_ff.bits >> bp_ff;
      keep_mask = ~({WIN_W{1'b1}} >> fill);
      window    = ({partial_ff, 64'd0} | shifted) & keep_mask;
      win_bytes = {window, 8'd0};
      nbytes    = fill[6:3];
   end

   always_comb begin
      partial_in = partial_ff;
      bp_in      = bp_ff;
      count_in   = count_ff;
      left_in    = left_ff;
      ovf_in     = ovf_ff;
      buf_n_in   = 4'd1;
      buf_bv_in  = 1'b0;
      for (int i = 0; i < MAX_RES; i++) begin
         buf_bytes_in[i] = win_bytes[9 - i];
      end
      case (p4_ff.kind)
         KIND_FIXED, KIND_UE, KIND_SE, KIND_TRAIL: begin
            partial_in = win_bytes[4'd9 - nbytes];
            bp_in      = fill[2:0];
            count_in   = count_ff + CNT_W'(nbytes);
            left_in    = left_ff - LEFT_W'(nbytes);
            ovf_in     = ovf_ff | dropped;
            if (nbytes == 4'd0) begin
               buf_bytes_in[0] = 8'd0;
            end else begin
               buf_n_in  = nbytes;
               buf_bv_in = 1'b1;
            end
         end
         KIND_FLUSH: begin
            buf_bytes_in[0] = partial_ff;
            buf_bv_in       = (bp_ff != 3'd0);
         end
         KIND_RESTART: begin
            partial_in      = 8'd0;
            bp_in           = 3'd0;
            count_in        = '0;
            left_in         = LEFT_W'(CAPACITY);
            ovf_in          = 1'b0;
            buf_bytes_in[0] = 8'd0;
         end
         default: begin
            buf_bytes_in[0] = 8'd0;
         end
      endcase
      total_full   = {count_in, bp_in};
      buf_total_in = 14'(total_full);
      buf_ovf_in   = ovf_in;
   end

   // ---------------- result buffer control ----------------
   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_idx_in   = buf_idx_ff;
      if (adv4) begin
         buf_valid_in = 1'b1;
         buf_idx_in   = 4'd0;
      end else if (buf_done) begin
         buf_valid_in = 1'b0;
      end else if (rsp_take) begin
         buf_idx_in = buf_idx_ff + 4'd1;
      end
   end

   assign rsp_valid           = buf_valid_ff;
   assign rsp_data.out_byte   = buf_bytes_ff[buf_idx_ff];
   assign rsp_data.byte_valid = buf_bv_ff;
   assign rsp_data.is_last    = (buf_idx_ff == buf_n_ff - 4'd1);
   assign rsp_data.overflowed = buf_ovf_ff;
   assign rsp_data.bit_total  = buf_total_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         buf_valid_ff <= 1'b0;
         buf_idx_ff   <= 4'd0;
         partial_ff   <= 8'd0;
         bp_ff        <= 3'd0;
         count_ff     <= '0;
         left_ff      <= LEFT_W'(CAPACITY);
         ovf_ff       <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         buf_valid_ff <= buf_valid_in;
         buf_idx_ff   <= buf_idx_in;
         if (adv4) begin
            partial_ff <= partial_in;
            bp_ff      <= bp_in;
            count_ff   <= count_in;
            left_ff    <= left_in;
            ovf_ff     <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) p1_ff <= p1_in;
      if (adv1) p2_ff <= p2_in;
      if (adv2) p3_ff <= p3_in;
      if (adv3) p4_ff <= p4_in;
      if (adv4) begin
         buf_n_ff     <= buf_n_in;
         buf_bv_ff    <= buf_bv_in;
         buf_ovf_ff   <= buf_ovf_in;
         buf_total_ff <= buf_total_in;
         buf_bytes_ff <= buf_bytes_in;
      end
   end

   // ---------------- assertions ----------------
   // byte count and remaining room always add up to the capacity
   a_room_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) + 32'(left_ff)) == 32'(CAPACITY))
      else $error("byte count and remaining room disagree");

   // a loaded result buffer holds 1..9 transactions and the read index stays inside
   a_buf_bounds: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (buf_n_ff != 4'd0 && buf_n_ff <= 4'(MAX_RES) && buf_idx_ff < buf_n_ff))
      else $error("result buffer count or index out of range");

   // a taken rsp that is not the last one moves on to the next byte of the same element
   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_data.is_last) |=> (rsp_valid && buf_idx_ff == $past(buf_idx_ff) + 4'd1))
      else $error("result buffer lost or skipped a byte");

   // packer state only moves when an element is packed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !adv4 |=> ($stable(bp_ff) && $stable(count_ff) && $stable(ovf_ff)))
      else $error("packer state changed without a packed element");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the Exp-Golomb bit writer: directed and random syntax elements.
`timescale 1ns / 1ps

module tb_top;
   import ebw_pkg::*;

   // Idle draw range per transaction, on both sides.
   localparam int IDLE_MAX       = 12;
   // Consecutive cycles with no transaction on either channel before the run is abandoned.
   // Worst correct case is a sender gap of IDLE_MAX plus five pipeline stages, or a
   // receiver stall of IDLE_MAX per byte, so this is far above any legal quiet stretch.
   localparam int WATCHDOG_LIMIT = 2000;
   // Extra cycles after the last expected byte, to catch stray transactions.
   localparam int DRAIN_CYCLES   = 20;
   localparam int REPORT_MAX     = 10;

   // Kind codes the block must ignore (status transaction only).
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // When set, neither side idles: back-to-back traffic.
   logic    steady;

   int      mismatch_count = 0;
   int      quiet_cycles   = 0;

   exp_golomb_bit_writer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Bit packer model. Mirrors the stream state: pending byte, fill position, completed
   // byte count and the sticky overflow flag. Each accepted element turns into one or more
   // expected response transactions, queued in stream order.
   // ---------------------------------------------------------------------------------------
   logic [7:0]  pk_byte;
   logic [2:0]  pk_bits;
   int unsigned pk_count;
   logic        pk_ovf;
   logic [7:0]  fresh_bytes[$];     // bytes completed by the element being packed
   rsp_type     expected_stream[$];
   rsp_type     want;

   initial begin
      pk_byte  = '0;
      pk_bits  = '0;
      pk_count = 0;
      pk_ovf   = 1'b0;
   end

   // One bit, MSB first. At capacity the bit is lost and overflow sticks.
   task automatic put_bit(input logic b);
      if (pk_count >= CAPACITY) begin
         pk_ovf = 1'b1;
         return;
      end
      pk_byte[3'd7 - pk_bits] = b;
      if (pk_bits == 3'd7) begin
         fresh_bytes.push_back(pk_byte);
         pk_count++;
         pk_byte = '0;
         pk_bits = '0;
      end else begin
         pk_bits++;
      end
   endtask

   // Low n bits of v, most significant first; n above 32 writes leading zeros.
   task automatic put_field(input int unsigned n, input logic [63:0] v);
      for (int i = n; i > 0; i--)
         put_bit(v[i-1]);
   endtask

   // ue(v): code = v+1 in 33 bits, prefix of floor(log2(code)) zeros, then code itself.
   task automatic put_ue(input logic [31:0] v);
      logic [63:0] code;
      int unsigned len;
      code = {32'd0, v} + 64'd1;
      len  = 0;
      while ((code >> len) > 64'd1)
         len++;
      put_field(len, 64'd0);
      put_field(len + 1, code);
   endtask

   // se(v): zig-zag modulo 2^32, so the most negative value lands on zero.
   task automatic put_se(input logic [31:0] v);
      logic [31:0] mapped;
      if (v == 32'd0 || v[31])
         mapped = (32'd0 - v) << 1;
      else
         mapped = (v << 1) - 32'd1;
      put_ue(mapped);
   endtask

   // RBSP trailing bits: a one, then zeros up to the byte boundary (stops at capacity).
   task automatic put_trailing();
      put_bit(1'b1);
      while (pk_bits != 3'd0 && pk_count < CAPACITY)
         put_bit(1'b0);
   endtask

   function automatic rsp_type make_rsp(input logic [7:0] b, input logic v, input logic l,
                                        input logic [13:0] total);
      rsp_type r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.is_last    = l;
      r.overflowed = pk_ovf;
      r.bit_total  = total;
      return r;
   endfunction

   task automatic pack_element(input req_type t);
      logic [13:0] total;
      logic        flush;
      fresh_bytes.delete();
      flush = 1'b0;
      case (t.kind)
         KIND_FIXED:   put_field(t.bit_width, {32'd0, t.value});
         KIND_UE:      put_ue(t.value);
         KIND_SE:      put_se(t.value);
         KIND_TRAIL:   put_trailing();
         KIND_FLUSH:   flush = 1'b1;
         KIND_RESTART: begin
            pk_byte  = '0;
            pk_bits  = '0;
            pk_count = 0;
            pk_ovf   = 1'b0;
         end
         default: ;
      endcase
      total = 14'(pk_count * 8 + pk_bits);
      // Flush reports the zero-padded partial byte; otherwise one transaction per
      // completed byte, or a single status transaction when none completed.
      if (flush)
         expected_stream.push_back(make_rsp(pk_byte, pk_bits != 3'd0, 1'b1, total));
      else if (fresh_bytes.size() == 0)
         expected_stream.push_back(make_rsp(8'd0, 1'b0, 1'b1, total));
      else
         foreach (fresh_bytes[k])
            expected_stream.push_back(make_rsp(fresh_bytes[k], 1'b1,
                                               k == fresh_bytes.size() - 1, total));
   endtask

   // Predict on every accepted request transaction. Sampled at the rising edge, before
   // the block's own registers update in this time step.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pack_element(req_data);
   end

   // Compare every accepted response transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stream.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected rsp: byte=%h valid=%b last=%b ovf=%b total=%0d",
                        rsp_data.out_byte, rsp_data.byte_valid, rsp_data.is_last,
                        rsp_data.overflowed, rsp_data.bit_total);
         end else begin
            want = expected_stream.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("rsp mismatch: exp byte=%h valid=%b last=%b ovf=%b total=%0d",
                           want.out_byte, want.byte_valid, want.is_last, want.overflowed,
                           want.bit_total);
                  $display("              got byte=%h valid=%b last=%b ovf=%b total=%0d",
                           rsp_data.out_byte, rsp_data.byte_valid, rsp_data.is_last,
                           rsp_data.overflowed, rsp_data.bit_total);
               end
            end
         end
      end
   end

   // Watchdog: ends a hung run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Cycles to wait before the next transaction: none when steady, else half the time none, else 1..IDLE_MAX.
   function automatic int unsigned draw_gap();
      if (steady || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(1, IDLE_MAX);
   endfunction

   // Receiver: random stall ahead of each response transaction. Changes at falling edges.
   initial begin : rsp_side
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         hold = draw_gap();
         @(negedge clock);
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Sender: optional idle gap, then hold the element until the block accepts it.
   // Valid stays high across back-to-back transactions; it only drops for a gap.
   task automatic send_element(input logic [2:0] k, input logic [31:0] v,
                               input logic [5:0] w);
      req_type     t;
      int unsigned gap;
      t.kind      = k;
      t.value     = v;
      t.bit_width = w;
      gap         = draw_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = t;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // u(n) edges: zero width, single bit, full 32, and widths past 32 (zero-extended).
   task automatic test_fixed_width();
      send_element(KIND_FIXED, 32'hFFFF_FFFF, 6'd0);
      send_element(KIND_FIXED, 32'h0000_0001, 6'd1);
      send_element(KIND_FIXED, 32'hFFFF_FFFF, 6'd32);
      send_element(KIND_FIXED, 32'h0000_0000, 6'd32);
      send_element(KIND_FIXED, 32'hA5A5_A5A5, 6'd63);
      send_element(KIND_FIXED, 32'h5A5A_5A5A, 6'd33);
      send_element(KIND_FIXED, 32'h0000_0055, 6'd7);
   endtask

   // ue/se extremes: the widest code (33 bits, from ue of all-ones), and the most negative se value
   // that wraps onto ue(0).
   task automatic test_exp_golomb();
      send_element(KIND_UE, 32'h0000_0000, 6'd0);
      send_element(KIND_UE, 32'h0000_0001, 6'd0);
      send_element(KIND_UE, 32'hFFFF_FFFF, 6'd0);
      send_element(KIND_UE, 32'hFFFF_FFFE, 6'd0);
      send_element(KIND_SE, 32'h0000_0000, 6'd0);
      send_element(KIND_SE, 32'h0000_0001, 6'd0);
      send_element(KIND_SE, 32'hFFFF_FFFF, 6'd0);
      send_element(KIND_SE, 32'h7FFF_FFFF, 6'd0);
      send_element(KIND_SE, 32'h8000_0000, 6'd0);
   endtask

   // Flush with and without pending bits, trailing bits mid-byte and aligned,
   // ignored kinds, restart in the middle of a byte.
   task automatic test_control_kinds();
      send_element(KIND_FIXED, 32'h0000_0005, 6'd3);
      send_element(KIND_FLUSH, 32'hFFFF_FFFF, 6'd63);
      send_element(KIND_TRAIL, 32'h0000_0000, 6'd0);
      send_element(KIND_FLUSH, 32'h0000_0000, 6'd0);
      send_element(KIND_SPARE_6, 32'hFFFF_FFFF, 6'd32);
      send_element(KIND_SPARE_7, 32'h1234_5678, 6'd5);
      send_element(KIND_FIXED, 32'h0000_0013, 6'd5);
      send_element(KIND_RESTART, 32'h0000_0000, 6'd0);
      send_element(KIND_TRAIL, 32'h0000_0000, 6'd0);
   endtask

   // Mixed stream. Code lengths are spread by shifting the random value, so short
   // and long Exp-Golomb codes both show up; restarts are rare so the stream grows.
   task automatic test_random_stream(input int unsigned n);
      int unsigned pick;
      logic [2:0]  k;
      logic [31:0] v;
      logic [5:0]  w;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         v    = $urandom;
         w    = 6'($urandom_range(0, 32));
         if (pick < 35) begin
            k = KIND_FIXED;
            if ($urandom_range(0, 9) == 0)
               w = 6'($urandom_range(33, 63));
         end else if (pick < 57) begin
            k = KIND_UE;
            v = v >> $urandom_range(0, 31);
         end else if (pick < 79) begin
            k = KIND_SE;
            v = v >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1)
               v = 32'd0 - v;
         end else if (pick < 88) begin
            k = KIND_TRAIL;
         end else if (pick < 95) begin
            k = KIND_FLUSH;
         end else if (pick < 98) begin
            k = KIND_RESTART;
         end else begin
            k = ($urandom_range(0, 1) == 1) ? KIND_SPARE_6 : KIND_SPARE_7;
         end
         send_element(k, v, w);
      end
      steady = 1'b0;
   endtask

   // Fill the stream past capacity with long ue codes (63 or 65 bits each), then
   // check that every kind behaves at capacity and that restart clears the flag.
   task automatic test_capacity();
      logic [31:0] v;
      send_element(KIND_RESTART, 32'h0000_0000, 6'd0);
      for (int i = 0; i < 135; i++) begin
         steady = (i >= 40 && i < 90);
         v = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
         send_element(KIND_UE, v, 6'd0);
      end
      steady = 1'b0;
      send_element(KIND_FIXED, $urandom, 6'd32);
      send_element(KIND_FIXED, $urandom, 6'd0);
      send_element(KIND_SE, $urandom, 6'd0);
      send_element(KIND_TRAIL, 32'h0000_0000, 6'd0);
      send_element(KIND_FLUSH, 32'h0000_0000, 6'd0);
      send_element(KIND_SPARE_6, 32'h0000_0000, 6'd0);
      send_element(KIND_RESTART, 32'h0000_0000, 6'd0);
      send_element(KIND_FIXED, 32'h0000_00C3, 6'd8);
      send_element(KIND_FIXED, 32'h0000_0002, 6'd2);
      send_element(KIND_FLUSH, 32'h0000_0000, 6'd0);
   endtask

   initial begin : run
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      steady    = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fixed_width();
      test_exp_golomb();
      test_control_kinds();
      test_random_stream(180);
      test_capacity();

      @(negedge clock);
      req_valid = 1'b0;
      // Drain: the watchdog catches any expectation that never arrives.
      while (expected_stream.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ebw_pkg.sv
rtl/exp_golomb_bit_writer.sv
dv/tb_top.sv
